// ----- rtl/core/a2d_pkg.sv -----
// Shared types, constants and helper functions for the affine transform engine.
`default_nettype none
package a2d_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANG_FRAC         = 30;
  localparam int ZW               = 36;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ZW-1:0] INV_GAIN    = 36'sd652032874;

  // 2^62 / TWO_PI_Q30, rounded; quotient estimate for the angle reduction
  localparam logic signed [31:0] RECIP_2PI = 32'sd683565276;

  typedef enum logic [2:0] {
    FN_IDENT = 3'd0,
    FN_TRANS = 3'd1,
    FN_ROT   = 3'd2,
    FN_SCALE = 3'd3,
    FN_XFORM = 3'd4
  } func_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;     // capture func and arguments
    logic       ident;    // matrix to identity
    logic       cor_init; // load CORDIC start values
    logic       cor_step; // run one CORDIC iteration
    logic       cor_fin;  // round and fold CORDIC results
    logic       lrow_set; // build command matrix
    logic       mac;      // one multiply-accumulate step
    logic [3:0] mac_idx;  // product index
    logic       commit;   // write new matrix
    logic       res_set;  // latch transform result
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       cor_last;
  } sts_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 36'sd843314857;
      1: r = 36'sd497837829;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      default: r = ZW'(64'sd1 <<< (ANG_FRAC - i));
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/affine_2d_transform_engine.sv -----
// Top level of the 2D affine transform engine.
`default_nettype none
// Keeps a Q(32-FRAC_BITS).FRAC_BITS 2x3 affine matrix (bottom row 0 0 1). func 0 resets it to
// identity, 1/2/3 left-multiply by translate(arg_a,arg_b), rotate(arg_a radians) or
// scale(arg_a,arg_b); 4 transforms point (arg_a,arg_b) and returns out_x/out_y as one
// transaction. Codes 5..7 do nothing. One transaction at a time; rotate first reduces the
// angle modulo 2*pi, and transform holds its result until out_ready is high. Run time is
// set by the serial CORDIC iteration and the shared 32x32 multiplier, which handles one
// rounded product per cycle. All sums saturate to 32 bits.
module affine_2d_transform_engine #(
  parameter int FRAC_BITS    = a2d_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = a2d_pkg::CORDIC_STEPS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [2:0]        func,
  input  wire  signed [31:0] arg_a,
  input  wire  signed [31:0] arg_b,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y
);
  import a2d_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [$clog2(CORDIC_STEPS)-1:0] step;

  // sequence each command through the datapath
  a2d_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd, .step
  );

  // hold matrix, run CORDIC and the shared MAC
  a2d_dp #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk, .rst, .func, .arg_a, .arg_b, .cmd, .step, .sts, .out_x, .out_y
  );
endmodule
`default_nettype wire

// ----- rtl/core/a2d_ctrl.sv -----
// Command sequencer for the affine transform engine.
`default_nettype none
module a2d_ctrl #(
  parameter int CORDIC_STEPS = a2d_pkg::CORDIC_STEPS_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  a2d_pkg::sts_t    sts,
  output a2d_pkg::cmd_t    cmd,
  output logic [$clog2(CORDIC_STEPS)-1:0] step
);
  import a2d_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_RED1 = 9'b000000100,
    S_RED2 = 9'b000001000,
    S_COR  = 9'b000010000,
    S_FIN  = 9'b000100000,
    S_MAC  = 9'b001000000,
    S_WB   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  localparam int SW = $clog2(CORDIC_STEPS);
  state_t state, state_next;
  logic [3:0] idx;
  logic [3:0] last_idx;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign last_idx  = (sts.func == FN_XFORM) ? 4'd3 : 4'd11;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mac_idx = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.func == FN_IDENT) begin
          cmd.ident = 1'b1;
          state_next = S_IDLE;
        end else if (sts.func == FN_ROT) begin
          state_next = S_RED1;
        end else if (sts.func inside {FN_TRANS, FN_SCALE, FN_XFORM}) begin
          cmd.lrow_set = 1'b1;
          state_next = S_MAC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RED1: begin
        state_next = S_RED2;
      end
      S_RED2: begin
        cmd.cor_init = 1'b1;
        state_next = S_COR;
      end
      S_COR: begin
        cmd.cor_step = 1'b1;
        if (sts.cor_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.cor_fin = 1'b1;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (idx == last_idx) state_next = S_WB;
      end
      S_WB: begin
        if (sts.func == FN_XFORM) begin
          cmd.res_set = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_MAC) idx <= (idx == last_idx) ? 4'd0 : idx + 4'd1;
      else idx <= '0;
      if (state == S_COR) step <= step + SW'(1);
      else step <= '0;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/a2d_dp.sv -----
// Datapath: matrix store, CORDIC and shared multiply-accumulate.
`default_nettype none
module a2d_dp #(
  parameter int FRAC_BITS    = a2d_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = a2d_pkg::CORDIC_STEPS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  [2:0]          func,
  input  wire  signed [31:0]  arg_a,
  input  wire  signed [31:0]  arg_b,
  input  a2d_pkg::cmd_t       cmd,
  input  wire  [$clog2(CORDIC_STEPS)-1:0] step,
  output a2d_pkg::sts_t       sts,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y
);
  import a2d_pkg::*;

  localparam int SW = $clog2(CORDIC_STEPS);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam int CSH = ANG_FRAC - FRAC_BITS;
  localparam int RSH = 62 - CSH;
  localparam logic signed [ZW-1:0] CHALF = ZW'(64'sd1 <<< (CSH - 1));

  logic [2:0] fn;
  logic signed [31:0] a, b;
  logic signed [31:0] m [6];
  logic signed [31:0] l [6];
  logic signed [31:0] n [6];
  logic signed [ZW-1:0] cx, cy, cz;
  logic flip;
  logic signed [47:0] acc;

  assign sts.func = fn;
  assign sts.cor_last = (step == SW'(CORDIC_STEPS - 1));

  // angle reduction modulo 2*pi: estimate the quotient by a reciprocal
  // multiply, subtract, then fix the estimate by one add or subtract
  logic signed [55:0] zw;
  logic signed [63:0] rprod;
  logic signed [23:0] red_q;
  logic signed [59:0] qt;
  logic signed [47:0] red_r;
  assign zw    = 56'(a) <<< CSH;
  assign rprod = a * RECIP_2PI;
  assign qt    = red_q * TWO_PI_Q30;

  always_ff @(posedge clk) begin
    red_q <= 24'(rprod >>> RSH);
    red_r <= 48'(zw - 56'(qt));
  end

  // bring the remainder into (-pi, pi], then quadrant fold
  logic signed [47:0] zr;
  logic signed [ZW-1:0] zm, zf;
  logic fl;
  always_comb begin
    zr = red_r;
    if (zr < 0) zr = zr + 48'(TWO_PI_Q30);
    else if (zr >= 48'(TWO_PI_Q30)) zr = zr - 48'(TWO_PI_Q30);
    zm = zr[ZW-1:0];
    if (zm > PI_Q30) zm = zm - TWO_PI_Q30;
    fl = 1'b0;
    zf = zm;
    if (zm > HALF_PI_Q30) begin
      zf = zm - PI_Q30; fl = 1'b1;
    end else if (zm < -HALF_PI_Q30) begin
      zf = zm + PI_Q30; fl = 1'b1;
    end
  end

  // CORDIC rotation step
  logic signed [ZW-1:0] atv, cxs, cys;
  always_comb begin
    atv = atan_entry(int'(step));
    cxs = cx >>> step;
    cys = cy >>> step;
  end

  // shared multiplier operand select; product order matches the row sums
  logic [2:0] ent;
  assign ent = cmd.mac_idx[3:1];

  logic signed [31:0] opa, opb;
  logic [2:0] ra, rb, cc;
  always_comb begin
    ra = '0; rb = '0; cc = '0;
    opa = '0; opb = '0;
    if (fn == FN_XFORM) begin
      ra = {cmd.mac_idx[1], 1'b0} + {1'b0, cmd.mac_idx[1]} + {2'b0, cmd.mac_idx[0]};
      opa = m[ra];
      opb = cmd.mac_idx[0] ? b : a;
    end else begin
      if (ent >= 3'd3) begin
        ra = 3'd3 + {2'b0, cmd.mac_idx[0]};
        cc = ent - 3'd3;
      end else begin
        ra = {2'b0, cmd.mac_idx[0]};
        cc = ent;
      end
      rb = cc + (cmd.mac_idx[0] ? 3'd3 : 3'd0);
      opa = l[ra];
      opb = m[rb];
    end
  end
  logic signed [63:0] prod;
  logic signed [47:0] pr;
  assign prod = opa * opb;
  assign pr = 48'((prod + HALF) >>> FRAC_BITS);

  // the step completing a pair closes one result entry
  logic signed [49:0] sum;
  logic signed [31:0] addc;
  always_comb begin
    if (fn == FN_XFORM) addc = ent[0] ? m[5] : m[2];
    else addc = ((ent == 3'd2) || (ent == 3'd5)) ? l[ent] : 32'sd0;
    sum = 50'(acc) + 50'(pr) + 50'(addc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m[0] <= ONE; m[1] <= '0; m[2] <= '0;
      m[3] <= '0;  m[4] <= ONE; m[5] <= '0;
    end else begin
      if (cmd.ident) begin
        m[0] <= ONE; m[1] <= '0; m[2] <= '0;
        m[3] <= '0;  m[4] <= ONE; m[5] <= '0;
      end
      if (cmd.commit) m <= n;
    end
    if (cmd.load) begin
      fn <= func; a <= arg_a; b <= arg_b;
    end
    if (cmd.cor_init) begin
      cx <= INV_GAIN; cy <= '0; cz <= zf; flip <= fl;
    end
    if (cmd.cor_step) begin
      if (!cz[ZW-1]) begin
        cx <= cx - cys; cy <= cy + cxs; cz <= cz - atv;
      end else begin
        cx <= cx + cys; cy <= cy - cxs; cz <= cz + atv;
      end
    end
    if (cmd.cor_fin) begin
      l[0] <= flip ? -32'((cx + CHALF) >>> CSH) : 32'((cx + CHALF) >>> CSH);
      l[4] <= flip ? -32'((cx + CHALF) >>> CSH) : 32'((cx + CHALF) >>> CSH);
      l[3] <= flip ? -32'((cy + CHALF) >>> CSH) : 32'((cy + CHALF) >>> CSH);
      l[1] <= flip ? 32'((cy + CHALF) >>> CSH) : -32'((cy + CHALF) >>> CSH);
      l[2] <= '0; l[5] <= '0;
    end
    if (cmd.lrow_set) begin
      if (fn == FN_TRANS) begin
        l[0] <= ONE; l[1] <= '0; l[2] <= a; l[3] <= '0; l[4] <= ONE; l[5] <= b;
      end else begin
        l[0] <= a; l[1] <= '0; l[2] <= '0; l[3] <= '0; l[4] <= b; l[5] <= '0;
      end
    end
    if (cmd.cor_init || cmd.lrow_set) acc <= '0;
    if (cmd.mac) begin
      if (cmd.mac_idx[0]) begin
        n[ent] <= sat32(sum);
        acc <= '0;
      end else begin
        acc <= pr;
      end
    end
    if (cmd.res_set) begin
      out_x <= n[0]; out_y <= n[1];
    end
  end
endmodule
`default_nettype wire
